FILE: rtl/core/mfr_pkg.sv
// mfr_pkg: shared types, codes and helper functions of the modbus frame receiver
// used by mfr_regs, mfr_frame and modbus_frame_receiver_core; no dependencies

package mfr_pkg;

	// field widths fixed by the interface
	localparam int LEN_W    = 9;
	localparam int STAT_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int CRC_W    = 16;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// default frame buffer size
	localparam int MAX_FRAME_DEF = 256;

	// register word indexes
	localparam logic REG_FRAME_MODE = 1'b0;

	// frame modes
	localparam logic MODE_RTU   = 1'b0;
	localparam logic MODE_ASCII = 1'b1;

	// input item kinds
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_TIMEOUT = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// end of frame status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STAT_W-1:0] ST_TIMEOUT  = 2'd2;
	localparam logic [STAT_W-1:0] ST_SHORT    = 2'd3;

	// special characters and crc constants
	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA001;

	// one result of the frame logic
	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [BYTE_W-1:0]   payload;
		logic [STAT_W-1:0]   status;
		logic [LEN_W-1:0]    length;
	} mfr_res_t;

	// byte-wide crc-16 update, reflected polynomial
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// hex digit value, non-hex characters folded the same way
	function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
		logic signed [BYTE_W-1:0] d;
		logic [BYTE_W-1:0]        v;
		d = signed'(c - 8'd48);
		if (d > 8'sd41)
			v = c - 8'd87;
		else if (d > 8'sd9)
			v = c - 8'd55;
		else
			v = c - 8'd48;
		return v[3:0];
	endfunction

endpackage

FILE: rtl/core/mfr_regs.sv
// mfr_regs: apb-style configuration register (frame_mode) of the frame receiver
// depends on mfr_pkg for address and data widths, register index and mode codes

module mfr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [mfr_pkg::DATA_W-1:0]   pwdata,
	output logic [mfr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic                         frame_mode,
	output logic                         frame_clear
);

	logic wr_en;
	logic frame_mode_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == mfr_pkg::REG_FRAME_MODE);

	// mode register, any write restarts framing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= mfr_pkg::MODE_RTU;
		end else if (wr_en) begin
			frame_mode_q <= pwdata[0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			mfr_pkg::REG_FRAME_MODE: prdata = {{(mfr_pkg::DATA_W-1){1'b0}}, frame_mode_q};
			default:                 prdata = '0;
		endcase
	end

	assign frame_mode  = frame_mode_q;
	assign frame_clear = wr_en;

endmodule

FILE: rtl/core/mfr_frame.sv
// mfr_frame: frame state and combinational step logic for rtu and ascii framing
// depends on mfr_pkg for codes, crc and hex helper functions

module mfr_frame #(
	parameter int MAX_FRAME = mfr_pkg::MAX_FRAME_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         func,
	input  logic [mfr_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         frame_mode,
	input  logic                         frame_clear,
	output mfr_pkg::mfr_res_t            res
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic [mfr_pkg::BYTE_W-1:0] held0_q, held1_q, held0_n, held1_n;
	logic [1:0]                 held_count_q, held_count_n;
	logic [mfr_pkg::CRC_W-1:0]  crc_q, crc_n;
	logic [mfr_pkg::BYTE_W-1:0] sum_q, sum_n;
	logic [CNT_W-1:0]           byte_count_q, byte_count_n;
	logic                       phase_q, phase_n;
	logic [3:0]                 high_nib_q, high_nib_n;
	logic                       skip_q, skip_n;
	logic                       ovf_q, ovf_n;

	logic [CNT_W:0]             total;
	logic [mfr_pkg::BYTE_W-1:0] full;
	logic [mfr_pkg::LEN_W-1:0]  cur_len;
	logic                       clr;

	assign total   = {1'b0, byte_count_q} + (CNT_W+1)'(held_count_q);
	assign full    = {high_nib_q, mfr_pkg::hex_value(rx_byte)};
	assign cur_len = mfr_pkg::LEN_W'(byte_count_q);

	// next state and result for one item
	always_comb begin
		held0_n      = held0_q;
		held1_n      = held1_q;
		held_count_n = held_count_q;
		crc_n        = crc_q;
		sum_n        = sum_q;
		byte_count_n = byte_count_q;
		phase_n      = phase_q;
		high_nib_n   = high_nib_q;
		skip_n       = skip_q;
		ovf_n        = ovf_q;
		clr          = 1'b0;
		res          = '0;
		if (frame_mode == mfr_pkg::MODE_RTU) begin
			if (func == mfr_pkg::FUNC_TIMEOUT) begin
				// end of rtu frame, idle line reports nothing
				if (total != '0 || ovf_q) begin
					res.valid = 1'b1;
					res.kind  = mfr_pkg::KIND_END;
					clr       = 1'b1;
					if (total < (CNT_W+1)'(2)) begin
						res.status = mfr_pkg::ST_SHORT;
					end else if (ovf_q) begin
						res.status = mfr_pkg::ST_SHORT;
						res.length = cur_len;
					end else begin
						res.status = ({held1_q, held0_q} == crc_q) ?
							mfr_pkg::ST_OK : mfr_pkg::ST_MISMATCH;
						res.length = cur_len;
					end
				end
			end else if (total >= (CNT_W+1)'(MAX_FRAME)) begin
				ovf_n = 1'b1;
			end else if (held_count_q < 2'd2) begin
				// fill the two-byte delay
				if (held_count_q == 2'd0)
					held0_n = rx_byte;
				else
					held1_n = rx_byte;
				held_count_n = held_count_q + 2'd1;
			end else begin
				// oldest byte leaves the delay as payload
				held0_n      = held1_q;
				held1_n      = rx_byte;
				crc_n        = mfr_pkg::crc_byte(crc_q, held0_q);
				byte_count_n = byte_count_q + CNT_W'(1);
				res.valid    = 1'b1;
				res.kind     = mfr_pkg::KIND_PAYLOAD;
				res.payload  = held0_q;
			end
		end else begin
			if (func == mfr_pkg::FUNC_TIMEOUT) begin
				// ascii timeout is always an error report
				res.valid  = 1'b1;
				res.kind   = mfr_pkg::KIND_END;
				res.status = mfr_pkg::ST_TIMEOUT;
				res.length = cur_len;
				clr        = 1'b1;
				skip_n     = 1'b0;
			end else if (skip_q) begin
				skip_n = 1'b0;
			end else if (rx_byte == mfr_pkg::CHAR_COLON) begin
				skip_n = skip_q;
			end else if (rx_byte == mfr_pkg::CHAR_CR) begin
				// end of ascii frame, lrc sum must be zero
				res.valid = 1'b1;
				res.kind  = mfr_pkg::KIND_END;
				clr       = 1'b1;
				skip_n    = 1'b1;
				if (total < (CNT_W+1)'(2)) begin
					res.status = mfr_pkg::ST_SHORT;
				end else if (ovf_q) begin
					res.status = mfr_pkg::ST_SHORT;
					res.length = cur_len;
				end else begin
					res.status = (sum_q == '0) ? mfr_pkg::ST_OK : mfr_pkg::ST_MISMATCH;
					res.length = cur_len;
				end
			end else if (!phase_q) begin
				high_nib_n = mfr_pkg::hex_value(rx_byte);
				phase_n    = 1'b1;
			end else begin
				// second digit completes a byte, released one byte late
				phase_n = 1'b0;
				if (total >= (CNT_W+1)'(MAX_FRAME)) begin
					ovf_n = 1'b1;
				end else begin
					sum_n        = sum_q + full;
					held0_n      = full;
					held_count_n = 2'd1;
					if (held_count_q != 2'd0) begin
						res.valid    = 1'b1;
						res.kind     = mfr_pkg::KIND_PAYLOAD;
						res.payload  = held0_q;
						byte_count_n = byte_count_q + CNT_W'(1);
					end
				end
			end
		end
		// frame state back to its start values
		if (clr) begin
			held0_n      = '0;
			held1_n      = '0;
			held_count_n = '0;
			crc_n        = mfr_pkg::CRC_INIT;
			sum_n        = '0;
			byte_count_n = '0;
			phase_n      = 1'b0;
			high_nib_n   = '0;
			ovf_n        = 1'b0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q      <= '0;
			held1_q      <= '0;
			held_count_q <= '0;
			crc_q        <= mfr_pkg::CRC_INIT;
			sum_q        <= '0;
			byte_count_q <= '0;
			phase_q      <= 1'b0;
			high_nib_q   <= '0;
			skip_q       <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (frame_clear) begin
			held0_q      <= '0;
			held1_q      <= '0;
			held_count_q <= '0;
			crc_q        <= mfr_pkg::CRC_INIT;
			sum_q        <= '0;
			byte_count_q <= '0;
			phase_q      <= 1'b0;
			high_nib_q   <= '0;
			skip_q       <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (step) begin
			held0_q      <= held0_n;
			held1_q      <= held1_n;
			held_count_q <= held_count_n;
			crc_q        <= crc_n;
			sum_q        <= sum_n;
			byte_count_q <= byte_count_n;
			phase_q      <= phase_n;
			high_nib_q   <= high_nib_n;
			skip_q       <= skip_n;
			ovf_q        <= ovf_n;
		end
	end

endmodule

FILE: rtl/core/modbus_frame_receiver_core.sv
// modbus_frame_receiver_core: an accepted input beat goes into the input register,
// then through the frame step logic into the output register as its result beat
// throughput one input beat per cycle, set by the combinational frame step (one byte-wide crc)
// the input register advances whenever the output register is empty or being taken
// asynchronous active-low reset empties both registers, rtu mode, frame state cleared
// depends on mfr_pkg, mfr_regs and mfr_frame

module modbus_frame_receiver_core #(
	parameter int MAX_FRAME = mfr_pkg::MAX_FRAME_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [mfr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic [mfr_pkg::BYTE_W-1:0]   payload_byte,
	output logic [mfr_pkg::STAT_W-1:0]   frame_status,
	output logic [mfr_pkg::LEN_W-1:0]    frame_length,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [mfr_pkg::DATA_W-1:0]   pwdata,
	output logic [mfr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic                       valid_s1;
	logic                       func_s1;
	logic [mfr_pkg::BYTE_W-1:0] rx_byte_s1;
	logic                       valid_s2;
	mfr_pkg::mfr_res_t          res_s2;
	mfr_pkg::mfr_res_t          res;
	logic                       advance;
	logic                       frame_mode;
	logic                       frame_clear;

	mfr_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_mode  (frame_mode),
		.frame_clear (frame_clear)
	);

	// handshake between the two stages
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			rx_byte_s1 <= rx_byte;
		end
	end

	mfr_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.func        (func_s1),
		.rx_byte     (rx_byte_s1),
		.frame_mode  (frame_mode),
		.frame_clear (frame_clear),
		.res         (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign result_kind  = res_s2.kind;
	assign payload_byte = res_s2.payload;
	assign frame_status = res_s2.status;
	assign frame_length = res_s2.length;

endmodule

FILE: verif/mfr_checker.sv
// mfr_checker: watches the receive, result and register channels of the frame receiver,
// predicts every decoded byte and frame report and compares them in order
// depends on mfr_pkg; mfr_check_pkg below is shared with tb_top

package mfr_check_pkg;

	// byte address of the frame mode register
	localparam logic [mfr_pkg::ADDR_W-1:0] MODE_ADDR =
		mfr_pkg::ADDR_W'(4 * mfr_pkg::REG_FRAME_MODE);

	// one beat on the result channel
	typedef struct packed {
		logic                        kind;
		logic [mfr_pkg::BYTE_W-1:0]  data;
		logic [mfr_pkg::STAT_W-1:0]  status;
		logic [mfr_pkg::LEN_W-1:0]   length;
	} rx_result_t;

	// crc-16 over one byte, lsb first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		repeat (8)
			acc = acc[0] ? ((acc >> 1) ^ mfr_pkg::CRC_POLY) : (acc >> 1);
		return acc;
	endfunction

endpackage

module mfr_checker #(
	parameter int MAX_FRAME = mfr_pkg::MAX_FRAME_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         func,
	input  logic [mfr_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         result_kind,
	input  logic [mfr_pkg::BYTE_W-1:0]   payload_byte,
	input  logic [mfr_pkg::STAT_W-1:0]   frame_status,
	input  logic [mfr_pkg::LEN_W-1:0]    frame_length,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [mfr_pkg::DATA_W-1:0]   pwdata,
	input  logic [mfr_pkg::DATA_W-1:0]   prdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import mfr_pkg::*;
	import mfr_check_pkg::*;

	// mirror of the receiver state
	logic                mode_q;
	logic [BYTE_W-1:0]   held [2];
	logic [1:0]          held_n;
	logic [CRC_W-1:0]    crc_q;
	logic [BYTE_W-1:0]   lrc_q;
	logic [LEN_W-1:0]    sent_n;
	logic                odd_nib;
	logic [3:0]          hi_nib;
	logic                drop_next;
	logic                ovf_q;

	rx_result_t          decoded_q[$];
	rx_result_t          want;
	rx_result_t          got;
	int                  mismatches = 0;

	assign fail_count = mismatches;

	// clear everything that belongs to one frame
	function automatic void restart_frame();
		held[0] = '0;
		held[1] = '0;
		held_n  = '0;
		crc_q   = CRC_INIT;
		lrc_q   = '0;
		sent_n  = '0;
		odd_nib = 1'b0;
		hi_nib  = '0;
		ovf_q   = 1'b0;
	endfunction

	function automatic void queue_data_byte(input logic [BYTE_W-1:0] b);
		decoded_q.push_back('{KIND_PAYLOAD, b, ST_OK, '0});
	endfunction

	function automatic void queue_frame_end(input logic [STAT_W-1:0] st,
			input logic [LEN_W-1:0] len);
		decoded_q.push_back('{KIND_END, '0, st, len});
	endfunction

	// digit value of a character, non-hex characters folded by the same rule
	function automatic logic [3:0] digit_of(input logic [BYTE_W-1:0] c);
		logic signed [BYTE_W-1:0] d;
		d = c - 8'd48;
		if (d > 8'sd41)
			d = d - 8'sd39;
		else if (d > 8'sd9)
			d = d - 8'sd7;
		return d[3:0];
	endfunction

	// one accepted receive beat
	function automatic void decode_beat(input logic f, input logic [BYTE_W-1:0] b);
		int                fill;
		logic [BYTE_W-1:0] full;
		logic [LEN_W-1:0]  len;
		fill = int'(sent_n) + int'(held_n);
		len  = sent_n;
		if (mode_q == MODE_RTU) begin
			// rtu: two-byte delay line, crc over bytes leaving it
			if (f == FUNC_TIMEOUT) begin
				if (fill == 0 && !ovf_q)
					return;
				if (fill < 2)
					queue_frame_end(ST_SHORT, '0);
				else if (ovf_q)
					queue_frame_end(ST_SHORT, len);
				else
					queue_frame_end(({held[1], held[0]} == crc_q) ? ST_OK : ST_MISMATCH, len);
				restart_frame();
			end else if (fill >= MAX_FRAME) begin
				ovf_q = 1'b1;
			end else if (held_n < 2) begin
				held[held_n[0]] = b;
				held_n++;
			end else begin
				queue_data_byte(held[0]);
				crc_q   = crc16_step(crc_q, held[0]);
				held[0] = held[1];
				held[1] = b;
				sent_n++;
			end
		end else if (f == FUNC_TIMEOUT) begin
			// ascii: a silence always ends the frame as an error
			restart_frame();
			drop_next = 1'b0;
			queue_frame_end(ST_TIMEOUT, len);
		end else if (drop_next) begin
			drop_next = 1'b0;
		end else if (b == CHAR_CR) begin
			if (fill < 2)
				queue_frame_end(ST_SHORT, '0);
			else if (ovf_q)
				queue_frame_end(ST_SHORT, len);
			else
				queue_frame_end((lrc_q == '0) ? ST_OK : ST_MISMATCH, len);
			restart_frame();
			drop_next = 1'b1;
		end else if (b != CHAR_COLON) begin
			// hex digit pairs, each byte released one byte late
			if (!odd_nib) begin
				hi_nib  = digit_of(b);
				odd_nib = 1'b1;
			end else begin
				odd_nib = 1'b0;
				full    = {hi_nib, digit_of(b)};
				if (fill >= MAX_FRAME) begin
					ovf_q = 1'b1;
				end else begin
					lrc_q = lrc_q + full;
					if (held_n != 0) begin
						queue_data_byte(held[0]);
						sent_n++;
					end
					held[0] = full;
					held_n  = 2'd1;
				end
			end
		end
	endfunction

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    = MODE_RTU;
			drop_next = 1'b0;
			restart_frame();
			decoded_q.delete();
			pending_count <= 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && out_ready) begin
				got = '{result_kind, payload_byte, frame_status, frame_length};
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result kind=%0d byte=%02h status=%0d length=%0d",
							$realtime, got.kind, got.data, got.status, got.length);
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result mismatch, expected kind=%0d byte=%02h status=%0d ",
								"length=%0d, got kind=%0d byte=%02h status=%0d length=%0d"},
								$realtime, want.kind, want.data, want.status, want.length,
								got.kind, got.data, got.status, got.length);
					end
				end
			end

			if (in_valid && in_ready)
				decode_beat(func, rx_byte);

			// register access, a mode write drops the frame in progress
			if (psel && penable && pready && paddr == MODE_ADDR) begin
				if (pwrite) begin
					mode_q    = pwdata[0];
					drop_next = 1'b0;
					restart_frame();
				end else if (prdata !== {{(DATA_W-1){1'b0}}, mode_q}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mode readback mismatch, expected %0d, got %08h",
							$realtime, mode_q, prdata);
				end
			end

			pending_count <= decoded_q.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// tb_top: drives rtu and ascii frames, noise and silence events into the frame receiver,
// with random source gaps and sink stalls; verdict from mfr_checker
// depends on mfr_pkg, mfr_check_pkg, mfr_checker and modbus_frame_receiver_core

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mfr_pkg::*;
	import mfr_check_pkg::*;

	localparam int          FRAME_CAP     = MAX_FRAME_DEF;
	localparam int          ITEMS_TARGET  = 1350;
	localparam int          PHASE_ITEMS   = 160;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          SETTLE_CYCLES = 8;
	localparam logic [7:0]  CHAR_LF       = 8'h0A;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_SPARSE, SINK_HOLD} sink_style_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func     = FUNC_BYTE;
	logic [BYTE_W-1:0]    rx_byte  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 result_kind;
	logic [BYTE_W-1:0]    payload_byte;
	logic [STAT_W-1:0]    frame_status;
	logic [LEN_W-1:0]     frame_length;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [ADDR_W-1:0]    paddr    = '0;
	logic [DATA_W-1:0]    pwdata   = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int                   fail_count;
	int                   pending_count;
	int                   items_sent = 0;
	int                   burst_left = 0;
	int                   gap_max    = 4;
	bit                   hold_req   = 1'b0;

	modbus_frame_receiver_core #(.MAX_FRAME(FRAME_CAP)) DUT (.*);

	mfr_checker #(.MAX_FRAME(FRAME_CAP)) u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// one receive beat, then maybe a gap before the next burst
	task automatic send_beat(input logic f, input logic [BYTE_W-1:0] b);
		in_valid <= 1'b1;
		func     <= f;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) :
				$urandom_range(0, 12);
			gap_max    = ($urandom_range(0, 4) == 0) ? 20 : 4;
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_beat(FUNC_BYTE, b);
	endtask

	task automatic send_timeout();
		send_beat(FUNC_TIMEOUT, BYTE_W'($urandom));
	endtask

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
		return (n < 10) ? 8'd48 + n : (lower ? 8'd87 : 8'd55) + n;
	endfunction

	task automatic send_hex(input logic [BYTE_W-1:0] b, input bit lower);
		send_byte(hex_char(b[7:4], lower));
		send_byte(hex_char(b[3:0], lower));
	endtask

	// rtu frame: data, crc low then high, silence
	task automatic rtu_frame(input logic [BYTE_W-1:0] bytes[$], input bit bad_crc);
		logic [CRC_W-1:0] crc;
		crc = CRC_INIT;
		foreach (bytes[k]) begin
			crc = crc16_step(crc, bytes[k]);
			send_byte(bytes[k]);
		end
		if (bad_crc)
			crc ^= 16'h0001 << $urandom_range(0, 15);
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
		send_timeout();
	endtask

	// ascii frame: colon, hex data, lrc, optional stray character, cr, trailer
	task automatic ascii_frame(input logic [BYTE_W-1:0] bytes[$], input logic [BYTE_W-1:0] lrc_flip,
			input bit odd_tail, input logic [BYTE_W-1:0] tail_char,
			input logic [BYTE_W-1:0] trailer);
		logic [BYTE_W-1:0] sum;
		bit                lower;
		sum   = '0;
		lower = 1'($urandom_range(0, 1));
		send_byte(CHAR_COLON);
		foreach (bytes[k]) begin
			sum += bytes[k];
			send_hex(bytes[k], lower);
		end
		send_hex((~sum + 8'd1) ^ lrc_flip, lower);
		if (odd_tail)
			send_byte(tail_char);
		send_byte(CHAR_CR);
		send_byte(trailer);
	endtask

	// random characters and silences
	task automatic noise_burst();
		logic [BYTE_W-1:0] c;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 5))
				0: c = CHAR_COLON;
				1: c = CHAR_CR;
				2, 3: c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				default: c = BYTE_W'($urandom);
			endcase
			send_beat(($urandom_range(0, 7) == 0) ? FUNC_TIMEOUT : FUNC_BYTE, c);
		end
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop sending and wait for every predicted result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic set_mode(input logic m);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, MODE_ADDR, {{(DATA_W-1){1'b0}}, m});
		apb_access(1'b0, MODE_ADDR, '0);
	endtask

	// result sink: ready patterns, plus one long hold on request
	initial begin : sink
		sink_style_t style;
		int          span;
		int          tick;
		int          r;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				style    = SINK_HOLD;
				span     = $urandom_range(80, 120);
			end else begin
				r     = $urandom_range(0, 9);
				style = (r < 4) ? SINK_OPEN : (r < 7) ? SINK_COIN : (r < 9) ? SINK_THIRD :
					SINK_SPARSE;
				span  = $urandom_range(4, 60);
			end
			for (tick = 0; tick < span; tick++) begin
				@(posedge clk);
				case (style)
					SINK_OPEN:   out_ready <= 1'b1;
					SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
					SINK_THIRD:  out_ready <= (tick % 3 == 2);
					SINK_SPARSE: out_ready <= (tick % 8 == 7);
					default:     out_ready <= 1'b0;
				endcase
			end
		end
	end

	// give up after a long stretch with no beat on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] bytes_q[$];
		int                phase;
		int                phase_start;
		int                pick;
		int                n;
		bit                paused;
		logic              mode;

		@(posedge arst_n);
		@(posedge clk);

		// rtu corners: idle silence, single byte, empty frame, all-ones byte
		set_mode(MODE_RTU);
		send_timeout();
		send_byte(8'h00);
		send_timeout();
		bytes_q = {};
		rtu_frame(bytes_q, 1'b0);
		bytes_q = {8'hFF};
		rtu_frame(bytes_q, 1'b0);

		// ascii corners: stray digit and non-hex char, skipped trailer, silence, short frame
		set_mode(MODE_ASCII);
		bytes_q = {8'h01};
		ascii_frame(bytes_q, 8'h00, 1'b1, "Z", "x");
		send_byte("A");
		send_timeout();
		bytes_q = {};
		ascii_frame(bytes_q, 8'h80, 1'b0, 8'h00, CHAR_LF);

		paused = 1'b0;
		for (phase = 0; items_sent < ITEMS_TARGET || phase < 4; phase++) begin
			mode = (phase < 2) ? logic'(phase) : logic'($urandom_range(0, 1));
			set_mode(mode);
			if (phase == 0)
				hold_req = 1'b1;
			phase_start = items_sent;

			// one frame around the buffer limit in each mode
			if (phase < 2) begin
				bytes_q = {};
				n = (mode == MODE_RTU) ? $urandom_range(FRAME_CAP - 4, FRAME_CAP + 1) :
					$urandom_range(FRAME_CAP - 3, FRAME_CAP + 1);
				repeat (n) bytes_q.push_back(BYTE_W'($urandom));
				if (mode == MODE_RTU)
					rtu_frame(bytes_q, 1'b0);
				else
					ascii_frame(bytes_q, 8'h00, 1'b0, 8'h00, CHAR_LF);
			end

			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 24) == 0 ||
						(phase == 2 && !paused && items_sent - phase_start > 60)) begin
					paused = 1'b1;
					drain();
				end
				pick    = $urandom_range(0, 99);
				bytes_q = {};
				repeat ($urandom_range(0, 12)) bytes_q.push_back(BYTE_W'($urandom));
				if (mode == MODE_RTU) begin
					if (pick < 80) begin
						rtu_frame(bytes_q, pick >= 65);
					end else if (pick < 90) begin
						noise_burst();
					end else if (pick < 95) begin
						repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
						send_timeout();
					end else begin
						send_timeout();
					end
				end else begin
					if (pick < 72) begin
						ascii_frame(bytes_q,
							(pick >= 60) ? BYTE_W'($urandom_range(1, 255)) : 8'h00,
							$urandom_range(0, 4) == 0,
							($urandom_range(0, 1) == 0) ?
								hex_char(4'($urandom_range(0, 15)), 1'b0) :
								BYTE_W'($urandom),
							($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : CHAR_LF);
					end else if (pick < 82) begin
						// frame cut off by a silence
						send_byte(CHAR_COLON);
						repeat ($urandom_range(0, 5))
							send_hex(BYTE_W'($urandom), 1'($urandom_range(0, 1)));
						if ($urandom_range(0, 1) == 0)
							send_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
						send_timeout();
					end else begin
						noise_burst();
					end
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/mfr_pkg.sv
rtl/core/mfr_regs.sv
rtl/core/mfr_frame.sv
rtl/core/modbus_frame_receiver_core.sv
verif/mfr_checker.sv
verif/tb_top.sv
